/* hdl/audio_matrix_mixer_defines.svh */
// ----------------------------------------------------------------------------
// audio_matrix_mixer_defines.svh
// Assertion macros shared by the mixer RTL.
// ----------------------------------------------------------------------------
`ifndef AUDIO_MATRIX_MIXER_DEFINES_SVH
`define AUDIO_MATRIX_MIXER_DEFINES_SVH

// same-cycle implication
`define AMM_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mixer assertion failed");

// next-cycle implication
`define AMM_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mixer assertion failed");

`endif

/* hdl/amm_pkg.sv */
// ----------------------------------------------------------------------------
// amm_pkg
// Widths, command codes and shared types of the crosspoint matrix mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amm_pkg;

  localparam int PORTS           = 4;   // sample fields per item
  localparam int NUM_SIGNALS_DEF = 4;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 20;
  localparam int FRAC_W   = 16;         // Q4.16 gain
  localparam int CNT_W    = 3;
  localparam int XPT_W    = 2;          // crosspoint row / column index
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W = 1;

  localparam int PROD_W = SAMPLE_W + GAIN_W;
  localparam int TERM_W = PROD_W - FRAC_W;
  localparam int SUM_W  = TERM_W + $clog2(PORTS);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam logic [OP_W-1:0] OP_FRAME = 2'd0;
  localparam logic [OP_W-1:0] OP_GAIN  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INPUTS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUTS = 1'd1;

  localparam logic [CNT_W-1:0] COUNT_RESET = 3'd4;

  // load strobes of the two lane stages
  typedef struct packed {
    logic load_prod;
    logic load_sum;
  } pipe_ctl_t;

endpackage

/* hdl/amm_gain_table.sv */
// ----------------------------------------------------------------------------
// amm_gain_table
// Crosspoint gain storage: one Q4.16 gain per input/output pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "audio_matrix_mixer_defines.svh"

module amm_gain_table #(
  parameter int LANES = amm_pkg::NUM_SIGNALS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic                                  clr_en,
  input  logic [amm_pkg::XPT_W-1:0]             row,
  input  logic [amm_pkg::XPT_W-1:0]             col,
  input  logic signed [amm_pkg::GAIN_W-1:0]     value,
  output logic signed [amm_pkg::GAIN_W-1:0]     gain [LANES][LANES]
);

  logic [LANES*LANES*amm_pkg::GAIN_W-1:0] flat;

  for (genvar r = 0; r < LANES; r++) begin : g_row
    for (genvar c = 0; c < LANES; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (rst || clr_en) begin
          gain[r][c] <= '0;
        end else if (wr_en && row == amm_pkg::XPT_W'(r) && col == amm_pkg::XPT_W'(c)) begin
          gain[r][c] <= value;
        end
      end
      assign flat[(r*LANES+c)*amm_pkg::GAIN_W +: amm_pkg::GAIN_W] = gain[r][c];
    end
  end

  `AMM_ASSERT_NXT(a_clear_zeroes, clk, rst, clr_en, flat == '0)
  `AMM_ASSERT_NXT(a_idle_holds, clk, rst, !wr_en && !clr_en, $stable(flat))

endmodule

/* hdl/amm_lane.sv */
// ----------------------------------------------------------------------------
// amm_lane
// One output column: crosspoint products, then saturated column sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amm_lane #(
  parameter int LANES    = amm_pkg::NUM_SIGNALS_DEF,
  parameter int LANE_IDX = 0
) (
  input  logic                                 clk,
  input  amm_pkg::pipe_ctl_t                   ctl,
  input  logic [amm_pkg::CNT_W-1:0]            inputs_in_use,
  input  logic [amm_pkg::CNT_W-1:0]            outputs_in_use,
  input  logic signed [amm_pkg::SAMPLE_W-1:0]  sample [LANES],
  input  logic signed [amm_pkg::GAIN_W-1:0]    gain [LANES],
  output logic signed [amm_pkg::SAMPLE_W-1:0]  result
);

  localparam logic signed [amm_pkg::SUM_W-1:0] SUM_MAX =
    amm_pkg::SUM_W'(amm_pkg::SAMPLE_MAX);
  localparam logic signed [amm_pkg::SUM_W-1:0] SUM_MIN =
    amm_pkg::SUM_W'(amm_pkg::SAMPLE_MIN);

  logic                                 lane_on;
  logic signed [amm_pkg::GAIN_W-1:0]    gain_m [LANES];
  logic signed [amm_pkg::PROD_W-1:0]    prod [LANES];
  logic signed [amm_pkg::TERM_W-1:0]    term [LANES];
  logic signed [amm_pkg::SUM_W-1:0]     sum;

  assign lane_on = amm_pkg::CNT_W'(LANE_IDX) < outputs_in_use;

  for (genvar x = 0; x < LANES; x++) begin : g_xpt
    // unused inputs and outputs contribute through a zero gain
    assign gain_m[x] = (lane_on && amm_pkg::CNT_W'(x) < inputs_in_use) ? gain[x] : '0;
    assign prod[x]   = amm_pkg::PROD_W'(sample[x]) * amm_pkg::PROD_W'(gain_m[x]);

    // arithmetic shift right by the fraction width: floor
    always_ff @(posedge clk) begin
      if (ctl.load_prod) begin
        term[x] <= prod[x][amm_pkg::PROD_W-1:amm_pkg::FRAC_W];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int x = 0; x < LANES; x++) begin
      sum = sum + amm_pkg::SUM_W'(term[x]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_sum) begin
      if (sum > SUM_MAX) begin
        result <= amm_pkg::SAMPLE_MAX;
      end else if (sum < SUM_MIN) begin
        result <= amm_pkg::SAMPLE_MIN;
      end else begin
        result <= sum[amm_pkg::SAMPLE_W-1:0];
      end
    end
  end

endmodule

/* hdl/amm_merge.sv */
// ----------------------------------------------------------------------------
// amm_merge
// Output register: gathers the lane sums into one result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amm_merge #(
  parameter int LANES = amm_pkg::NUM_SIGNALS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sum_valid,
  input  logic                                 out_ready,
  input  logic signed [amm_pkg::SAMPLE_W-1:0]  lane_res [LANES],
  output logic                                 out_free,
  output logic                                 out_valid,
  output logic signed [amm_pkg::SAMPLE_W-1:0]  out_word [amm_pkg::PORTS]
);

  logic load;

  assign out_free = !out_valid || out_ready;
  assign load     = sum_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= sum_valid;
    end
  end

  for (genvar y = 0; y < amm_pkg::PORTS; y++) begin : g_out
    if (y < LANES) begin : g_lane
      always_ff @(posedge clk) begin
        if (load) begin
          out_word[y] <= lane_res[y];
        end
      end
    end else begin : g_none
      // no lane behind this output
      assign out_word[y] = '0;
    end
  end

endmodule

/* hdl/audio_matrix_mixer.sv */
// ----------------------------------------------------------------------------
// audio_matrix_mixer
// Crosspoint matrix mixer: per-output lanes multiply each input sample by
// its crosspoint gain and sum with 24-bit saturation.
// ----------------------------------------------------------------------------
// channel  handshake            payload
// in       in_valid/in_ready    op, in_sample_0..3, gain_row, gain_col, gain_value
// out      out_valid/out_ready  out_sample_0..3
// cfg      cfg_wr_en            cfg_index, cfg_data (no wait)
//
// One item per cycle sustained while out_ready is high. A sample frame passes
// three registers in order: products, lane sum, output register.
// Gain writes and clears take effect on the accepting edge and give no result.
// Reset is synchronous: gains zero, both counts 4. A stalled output backs up the
// three stages; in_ready drops only when all three hold an item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "audio_matrix_mixer_defines.svh"

module audio_matrix_mixer #(
  parameter int NUM_SIGNALS = amm_pkg::NUM_SIGNALS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [amm_pkg::OP_W-1:0]             op,
  input  logic signed [amm_pkg::SAMPLE_W-1:0]  in_sample_0,
  input  logic signed [amm_pkg::SAMPLE_W-1:0]  in_sample_1,
  input  logic signed [amm_pkg::SAMPLE_W-1:0]  in_sample_2,
  input  logic signed [amm_pkg::SAMPLE_W-1:0]  in_sample_3,
  input  logic [amm_pkg::XPT_W-1:0]            gain_row,
  input  logic [amm_pkg::XPT_W-1:0]            gain_col,
  input  logic signed [amm_pkg::GAIN_W-1:0]    gain_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [amm_pkg::SAMPLE_W-1:0]  out_sample_0,
  output logic signed [amm_pkg::SAMPLE_W-1:0]  out_sample_1,
  output logic signed [amm_pkg::SAMPLE_W-1:0]  out_sample_2,
  output logic signed [amm_pkg::SAMPLE_W-1:0]  out_sample_3,
  input  logic                                 cfg_wr_en,
  input  logic [amm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [amm_pkg::CNT_W-1:0]            cfg_data
);

  localparam int LANES = (NUM_SIGNALS < amm_pkg::PORTS) ? NUM_SIGNALS : amm_pkg::PORTS;

  logic [amm_pkg::CNT_W-1:0] inputs_in_use;
  logic [amm_pkg::CNT_W-1:0] outputs_in_use;

  logic               in_fire;
  logic               prod_valid;
  logic               sum_valid;
  logic               prod_free;
  logic               sum_free;
  logic               out_free;
  amm_pkg::pipe_ctl_t ctl;

  logic signed [amm_pkg::SAMPLE_W-1:0] all_smp [amm_pkg::PORTS];
  logic signed [amm_pkg::SAMPLE_W-1:0] lane_smp [LANES];
  logic signed [amm_pkg::GAIN_W-1:0]   tbl [LANES][LANES];
  logic signed [amm_pkg::GAIN_W-1:0]   lane_gain [LANES][LANES];
  logic signed [amm_pkg::SAMPLE_W-1:0] lane_res [LANES];
  logic signed [amm_pkg::SAMPLE_W-1:0] out_word [amm_pkg::PORTS];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      inputs_in_use  <= amm_pkg::COUNT_RESET;
      outputs_in_use <= amm_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        amm_pkg::REG_INPUTS:  inputs_in_use  <= cfg_data;
        amm_pkg::REG_OUTPUTS: outputs_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign sum_free  = !sum_valid || out_free;
  assign prod_free = !prod_valid || sum_free;
  assign in_ready  = prod_free;
  assign in_fire   = in_valid && in_ready;

  assign ctl.load_prod = in_fire && op == amm_pkg::OP_FRAME;
  assign ctl.load_sum  = prod_valid && sum_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      sum_valid  <= 1'b0;
    end else begin
      if (prod_free) begin
        prod_valid <= ctl.load_prod;
      end
      if (sum_free) begin
        sum_valid <= prod_valid;
      end
    end
  end

  amm_gain_table #(
    .LANES (LANES)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (in_fire && op == amm_pkg::OP_GAIN),
    .clr_en (in_fire && op == amm_pkg::OP_CLEAR),
    .row    (gain_row),
    .col    (gain_col),
    .value  (gain_value),
    .gain   (tbl)
  );

  assign all_smp[0] = in_sample_0;
  assign all_smp[1] = in_sample_1;
  assign all_smp[2] = in_sample_2;
  assign all_smp[3] = in_sample_3;

  for (genvar y = 0; y < LANES; y++) begin : g_lane
    assign lane_smp[y] = all_smp[y];
    for (genvar x = 0; x < LANES; x++) begin : g_tap
      assign lane_gain[y][x] = tbl[x][y];
    end

    amm_lane #(
      .LANES    (LANES),
      .LANE_IDX (y)
    ) u_lane (
      .clk            (clk),
      .ctl            (ctl),
      .inputs_in_use  (inputs_in_use),
      .outputs_in_use (outputs_in_use),
      .sample         (lane_smp),
      .gain           (lane_gain[y]),
      .result         (lane_res[y])
    );
  end

  amm_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .out_ready (out_ready),
    .lane_res  (lane_res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  assign out_sample_0 = out_word[0];
  assign out_sample_1 = out_word[1];
  assign out_sample_2 = out_word[2];
  assign out_sample_3 = out_word[3];

  `AMM_ASSERT_NXT(a_frame_enters, clk, rst, ctl.load_prod, prod_valid)
  `AMM_ASSERT_NXT(a_cmd_no_result, clk, rst, in_fire && op != amm_pkg::OP_FRAME, !prod_valid)
  `AMM_ASSERT_IMP(a_full_stalls, clk, rst,
                  prod_valid && sum_valid && out_valid && !out_ready, !in_ready)

endmodule

/* dv/tb_audio_matrix_mixer.sv */
// ----------------------------------------------------------------------------
// tb_audio_matrix_mixer
// Self-checking bench for the crosspoint mixer. A local gain table and count
// pair predict each sample frame at its accept edge; results are checked in
// order against the queue of predicted mixes. Reset state and directed extremes
// first, then count sweeps and random traffic, stalling both channels at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_audio_matrix_mixer;

  localparam logic [amm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [amm_pkg::GAIN_W-1:0] GAIN_MAX =
    {1'b0, {(amm_pkg::GAIN_W-1){1'b1}}};
  localparam logic signed [amm_pkg::GAIN_W-1:0] GAIN_MIN =
    {1'b1, {(amm_pkg::GAIN_W-1){1'b0}}};
  localparam logic signed [amm_pkg::GAIN_W-1:0] GAIN_UNITY = 20'sd65536;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [amm_pkg::OP_W-1:0]                                op;
    logic [amm_pkg::PORTS-1:0][amm_pkg::SAMPLE_W-1:0]        smp;
    logic [amm_pkg::XPT_W-1:0]                               row;
    logic [amm_pkg::XPT_W-1:0]                               col;
    logic [amm_pkg::GAIN_W-1:0]                              gval;
  } mix_cmd_t;

  typedef logic [amm_pkg::PORTS-1:0][amm_pkg::SAMPLE_W-1:0] mix_out_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [amm_pkg::OP_W-1:0] op;
  logic signed [amm_pkg::SAMPLE_W-1:0] in_sample_0, in_sample_1, in_sample_2, in_sample_3;
  logic [amm_pkg::XPT_W-1:0] gain_row, gain_col;
  logic signed [amm_pkg::GAIN_W-1:0] gain_value;
  logic out_valid;
  logic out_ready;
  logic signed [amm_pkg::SAMPLE_W-1:0] out_sample_0, out_sample_1, out_sample_2, out_sample_3;
  logic cfg_wr_en;
  logic [amm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [amm_pkg::CNT_W-1:0] cfg_data;

  // predictor state
  logic signed [amm_pkg::GAIN_W-1:0] gain_tab [amm_pkg::PORTS][amm_pkg::PORTS];
  logic [amm_pkg::CNT_W-1:0] cnt_in, cnt_out;
  mix_out_t mix_q [$];

  int err_count;
  int idle_pct;

  audio_matrix_mixer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .in_sample_0  (in_sample_0),
    .in_sample_1  (in_sample_1),
    .in_sample_2  (in_sample_2),
    .in_sample_3  (in_sample_3),
    .gain_row     (gain_row),
    .gain_col     (gain_col),
    .gain_value   (gain_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample_0 (out_sample_0),
    .out_sample_1 (out_sample_1),
    .out_sample_2 (out_sample_2),
    .out_sample_3 (out_sample_3),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic mix_out_t mix_frame(mix_cmd_t c);
    mix_out_t r;
    longint acc;
    longint prod;
    int nin;
    int nout;
    nin  = (cnt_in  > amm_pkg::PORTS) ? amm_pkg::PORTS : int'(cnt_in);
    nout = (cnt_out > amm_pkg::PORTS) ? amm_pkg::PORTS : int'(cnt_out);
    for (int y = 0; y < amm_pkg::PORTS; y++) begin
      acc = 0;
      if (y < nout) begin
        for (int x = 0; x < nin; x++) begin
          prod = longint'($signed(c.smp[x])) * longint'(gain_tab[x][y]);
          acc += prod >>> amm_pkg::FRAC_W;   // floor
        end
        if (acc > longint'(amm_pkg::SAMPLE_MAX)) acc = longint'(amm_pkg::SAMPLE_MAX);
        if (acc < longint'(amm_pkg::SAMPLE_MIN)) acc = longint'(amm_pkg::SAMPLE_MIN);
      end
      r[y] = acc[amm_pkg::SAMPLE_W-1:0];
    end
    return r;
  endfunction

  function automatic void apply_cmd(mix_cmd_t c);
    case (c.op)
      amm_pkg::OP_FRAME: mix_q.push_back(mix_frame(c));
      amm_pkg::OP_GAIN: begin
        if (c.row < amm_pkg::NUM_SIGNALS_DEF && c.col < amm_pkg::NUM_SIGNALS_DEF)
          gain_tab[c.row][c.col] = c.gval;
      end
      amm_pkg::OP_CLEAR: begin
        for (int x = 0; x < amm_pkg::PORTS; x++)
          for (int y = 0; y < amm_pkg::PORTS; y++)
            gain_tab[x][y] = '0;
      end
      default: ;   // unused op: no effect
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic mix_cmd_t mk(logic [amm_pkg::OP_W-1:0] o, int s0, int s1, int s2,
                                  int s3, int r, int c, int g);
    mix_cmd_t m;
    m.op     = o;
    m.smp[0] = s0[amm_pkg::SAMPLE_W-1:0];
    m.smp[1] = s1[amm_pkg::SAMPLE_W-1:0];
    m.smp[2] = s2[amm_pkg::SAMPLE_W-1:0];
    m.smp[3] = s3[amm_pkg::SAMPLE_W-1:0];
    m.row    = r[amm_pkg::XPT_W-1:0];
    m.col    = c[amm_pkg::XPT_W-1:0];
    m.gval   = g[amm_pkg::GAIN_W-1:0];
    return m;
  endfunction

  function automatic logic [amm_pkg::SAMPLE_W-1:0] rand_sample();
    logic signed [amm_pkg::SAMPLE_W-1:0] v;
    v = amm_pkg::SAMPLE_W'($urandom);
    case ($urandom_range(4))
      0: v = amm_pkg::SAMPLE_MAX;
      1: v = amm_pkg::SAMPLE_MIN;
      2: v = amm_pkg::SAMPLE_W'($urandom_range(2000) - 1000);
      3: v = v >>> $urandom_range(14);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [amm_pkg::GAIN_W-1:0] rand_gain();
    logic signed [amm_pkg::GAIN_W-1:0] v;
    v = amm_pkg::GAIN_W'($urandom);
    case ($urandom_range(5))
      0: v = GAIN_MAX;
      1: v = GAIN_MIN;
      2: v = amm_pkg::GAIN_W'(GAIN_UNITY + $urandom_range(512) - 256);
      3: v = amm_pkg::GAIN_W'(-GAIN_UNITY + $urandom_range(512) - 256);
      4: v = v >>> $urandom_range(10);
      default: ;
    endcase
    return v;
  endfunction

  function automatic mix_cmd_t rand_item();
    mix_cmd_t c;
    int pick;
    pick = int'($urandom_range(99));
    if (pick < 55)      c.op = amm_pkg::OP_FRAME;
    else if (pick < 89) c.op = amm_pkg::OP_GAIN;
    else if (pick < 93) c.op = amm_pkg::OP_CLEAR;
    else                c.op = OP_UNUSED;
    for (int x = 0; x < amm_pkg::PORTS; x++)
      c.smp[x] = rand_sample();
    c.row  = amm_pkg::XPT_W'($urandom_range(3));
    c.col  = amm_pkg::XPT_W'($urandom_range(3));
    c.gval = rand_gain();
    return c;
  endfunction

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_item(mix_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    op          = c.op;
    in_sample_0 = c.smp[0];
    in_sample_1 = c.smp[1];
    in_sample_2 = c.smp[2];
    in_sample_3 = c.smp[3];
    gain_row    = c.row;
    gain_col    = c.col;
    gain_value  = c.gval;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_cmd(c);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (mix_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [amm_pkg::CFG_IDX_W-1:0] idx,
                           logic [amm_pkg::CNT_W-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == amm_pkg::REG_INPUTS) cnt_in = data;
    else                            cnt_out = data;
  endtask

  task automatic set_counts(int ni, int no);
    wait_drained();
    write_reg(amm_pkg::REG_INPUTS, ni[amm_pkg::CNT_W-1:0]);
    write_reg(amm_pkg::REG_OUTPUTS, no[amm_pkg::CNT_W-1:0]);
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, logic [amm_pkg::SAMPLE_W-1:0] want,
                                 logic [amm_pkg::SAMPLE_W-1:0] got);
    $display("%0t mismatch %s: want %0d got %0d", $realtime, what,
             $signed(want), $signed(got));
    err_count++;
  endtask

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b1;
    else     out_ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    mix_out_t want;
    mix_out_t got;
    if (!rst && out_valid && out_ready) begin
      got = {out_sample_3, out_sample_2, out_sample_1, out_sample_0};
      if (mix_q.size() == 0) begin
        report_mismatch("unexpected item", '0, got[0]);
      end else begin
        want = mix_q.pop_front();
        for (int y = 0; y < amm_pkg::PORTS; y++)
          if (got[y] !== want[y])
            report_mismatch($sformatf("out_sample_%0d", y), want[y], got[y]);
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_reset_state();
    // zero gains after reset, default counts
    send_item(mk(amm_pkg::OP_FRAME, amm_pkg::SAMPLE_MAX, amm_pkg::SAMPLE_MIN, 12345, -1,
                 3, 3, GAIN_MAX));
    send_item(mk(amm_pkg::OP_FRAME, amm_pkg::SAMPLE_MIN, amm_pkg::SAMPLE_MAX, -777, 1,
                 0, 0, GAIN_MIN));
  endtask

  task automatic test_directed_extremes();
    send_item(mk(amm_pkg::OP_GAIN, amm_pkg::SAMPLE_MAX, 0, 0, 0, 0, 0, GAIN_MAX));
    send_item(mk(amm_pkg::OP_FRAME, amm_pkg::SAMPLE_MAX, 0, 0, 0, 0, 0, 0));
    send_item(mk(amm_pkg::OP_FRAME, amm_pkg::SAMPLE_MIN, 0, 0, 0, 0, 0, 0));
    send_item(mk(amm_pkg::OP_GAIN, 0, 0, 0, 0, 1, 1, GAIN_MIN));
    send_item(mk(amm_pkg::OP_FRAME, 0, amm_pkg::SAMPLE_MIN, 0, 0, 0, 0, 0));
    send_item(mk(amm_pkg::OP_FRAME, 0, amm_pkg::SAMPLE_MAX, 0, 0, 0, 0, 0));
    // unity and the smallest gain; negative products round down
    send_item(mk(amm_pkg::OP_GAIN, 0, 0, 0, 0, 2, 2, GAIN_UNITY));
    send_item(mk(amm_pkg::OP_GAIN, 0, 0, 0, 0, 3, 3, 1));
    send_item(mk(amm_pkg::OP_FRAME, -1, 1, -5, -1, 0, 0, 0));
    send_item(mk(amm_pkg::OP_GAIN, amm_pkg::SAMPLE_MIN, amm_pkg::SAMPLE_MIN,
                 amm_pkg::SAMPLE_MIN, amm_pkg::SAMPLE_MIN, 3, 0, -GAIN_UNITY));
    send_item(mk(amm_pkg::OP_FRAME, 1000, -3, 7, amm_pkg::SAMPLE_MIN, 3, 3, 0));
    // unused op must leave the table alone
    send_item(mk(OP_UNUSED, amm_pkg::SAMPLE_MAX, amm_pkg::SAMPLE_MAX, amm_pkg::SAMPLE_MAX,
                 amm_pkg::SAMPLE_MAX, 0, 0, 0));
    send_item(mk(amm_pkg::OP_FRAME, amm_pkg::SAMPLE_MAX, -2, 100, 65535, 1, 2, 5));
    // largest positive gain, then the all-ones gain (-1)
    send_item(mk(amm_pkg::OP_GAIN, 0, 0, 0, 0, 3, 3, GAIN_MAX));
    send_item(mk(amm_pkg::OP_FRAME, 1, 1, 1, amm_pkg::SAMPLE_MAX, 0, 0, 0));
    send_item(mk(amm_pkg::OP_FRAME, amm_pkg::SAMPLE_MIN, amm_pkg::SAMPLE_MIN,
                 amm_pkg::SAMPLE_MIN, amm_pkg::SAMPLE_MIN, 0, 0, 0));
    send_item(mk(amm_pkg::OP_CLEAR, amm_pkg::SAMPLE_MAX, amm_pkg::SAMPLE_MIN, -1, -1,
                 3, 3, -1));
    send_item(mk(amm_pkg::OP_FRAME, amm_pkg::SAMPLE_MAX, amm_pkg::SAMPLE_MAX,
                 amm_pkg::SAMPLE_MIN, amm_pkg::SAMPLE_MIN, 0, 0, 0));
    send_item(mk(amm_pkg::OP_GAIN, 0, 0, 0, 0, 0, 3, -1));
    send_item(mk(amm_pkg::OP_FRAME, -1, 0, 0, 0, 2, 1, GAIN_MAX));
    send_item(mk(amm_pkg::OP_FRAME, amm_pkg::SAMPLE_MIN, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_count_sweep();
    int ni_list [8] = '{4, 0, 1, 2, 3, 7, 6, 5};
    int no_list [8] = '{4, 3, 4, 1, 2, 5, 0, 7};
    for (int k = 0; k < 8; k++) begin
      set_counts(ni_list[k], no_list[k]);
      repeat (30) send_item(rand_item());
    end
  endtask

  task automatic test_random_traffic();
    set_counts(int'($urandom_range(7)), int'($urandom_range(7)));
    repeat (60) send_item(rand_item());
    set_counts(4, 4);
    repeat (60) send_item(rand_item());
  endtask

  task automatic test_back_to_back();
    // no idling on either side
    wait_drained();
    idle_pct = 0;
    repeat (60) send_item(rand_item());
    wait_drained();
    idle_pct = 19;
  endtask

  initial begin
    err_count   = 0;
    idle_pct    = 19;
    rst         = 1'b1;
    in_valid    = 1'b0;
    op          = amm_pkg::OP_FRAME;
    in_sample_0 = '0;
    in_sample_1 = '0;
    in_sample_2 = '0;
    in_sample_3 = '0;
    gain_row    = '0;
    gain_col    = '0;
    gain_value  = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = amm_pkg::REG_INPUTS;
    cfg_data    = amm_pkg::COUNT_RESET;
    cnt_in      = amm_pkg::COUNT_RESET;
    cnt_out     = amm_pkg::COUNT_RESET;
    for (int x = 0; x < amm_pkg::PORTS; x++)
      for (int y = 0; y < amm_pkg::PORTS; y++)
        gain_tab[x][y] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_state();
    test_directed_extremes();
    test_count_sweep();
    test_random_traffic();
    test_back_to_back();

    wait_drained();
    if (err_count == 0 && mix_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/amm_pkg.sv
hdl/amm_gain_table.sv
hdl/amm_lane.sv
hdl/amm_merge.sv
hdl/audio_matrix_mixer.sv
dv/tb_audio_matrix_mixer.sv
